FILE: src/cbmsi_pkg.sv
// Package for the cartridge bank mapper with scanline interrupt.
// Holds transfer structs, request and target codes, register decode constants.
package cbmsi_pkg;

  localparam int PRG_BANK_BITS = 8;
  localparam int CHR_BANK_BITS = 8;
  localparam logic [7:0] IRQ_THRESHOLD = 8'd238;

  localparam logic [7:0] PRG_FIELD_MASK = 8'((1 << PRG_BANK_BITS) - 1);
  localparam logic [7:0] CHR_FIELD_MASK = 8'((1 << CHR_BANK_BITS) - 1);

  localparam logic [8:0] SCANLINE_VISIBLE_END = 9'd240;

  localparam logic [15:0] DECODE_MASK = 16'hF003;
  localparam logic [15:0] REG_PRG0    = 16'h8000;
  localparam logic [15:0] REG_MIRROR  = 16'h9000;
  localparam logic [15:0] REG_PRG1    = 16'hA000;
  localparam logic [15:0] REG_CHR0    = 16'hB000;
  localparam logic [15:0] REG_CHR1    = 16'hB002;
  localparam logic [15:0] REG_CHR2    = 16'hC000;
  localparam logic [15:0] REG_CHR3    = 16'hC002;
  localparam logic [15:0] REG_CHR4    = 16'hD000;
  localparam logic [15:0] REG_CHR5    = 16'hD002;
  localparam logic [15:0] REG_CHR6    = 16'hE000;
  localparam logic [15:0] REG_CHR7    = 16'hE002;
  localparam logic [15:0] REG_IRQ     = 16'hF000;

  localparam logic CFG_PRG_MASK = 1'b0;
  localparam logic CFG_CHR_MASK = 1'b1;

  typedef enum logic [1:0] {
    REQ_WRITE    = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_CPU_READ = 2'd2,
    REQ_PPU_READ = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    TGT_NONE  = 2'd0,
    TGT_PRG   = 2'd1,
    TGT_CHR   = 2'd2,
    TGT_CIRAM = 2'd3
  } target_t;

  typedef struct packed {
    req_t        req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [8:0]  scanline;
  } in_item_t;

  typedef struct packed {
    logic [20:0] mem_addr;
    target_t     target;
    logic        irq_out;
  } out_item_t;

endpackage

FILE: src/cart_bank_mapper_scanline_irq.sv
// Top level of the cartridge bank mapper with scanline interrupt counter.
// Depends on cbmsi_pkg and cbmsi_xlate.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_ready   in_item_t   (request)
//   out_     output     out_valid/out_ready out_item_t  (translated result)
//   cfg_     input      cfg_we              cfg_index, cfg_wdata (bank masks)
//
// One transfer per cycle while in_ready is high; results are registered.
// Bank, mirror and interrupt state update at the request's transfer edge.
// An output register plus one skid entry let in_ready stay high while one
// result waits; in_ready drops only when both hold results.
// Reset (rst_n low, synchronous) clears all mapper state and sets masks to 255.
module cart_bank_mapper_scanline_irq
  import cbmsi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic [7:0]      prg_mask_r;
  logic [7:0]      chr_mask_r;
  logic [1:0][7:0] prg_banks_r, prg_banks_nxt;
  logic [7:0][7:0] chr_banks_r, chr_banks_nxt;
  logic            mirror_r, mirror_nxt;
  logic [7:0]      irq_cnt_r, irq_cnt_nxt;
  logic            irq_en_r, irq_en_nxt;
  logic            irq_lvl_r, irq_lvl_nxt;

  logic            out_valid_r, skid_valid_r;
  out_item_t       out_r, skid_r;
  out_item_t       result;
  logic [20:0]     xl_addr;
  target_t         xl_target;
  logic            push, pop;
  logic [7:0]      tick_cnt;
  logic [15:0]     dec_addr;

  cbmsi_xlate u_xlate (
    .item          (in_data),
    .prg_banks     (prg_banks_r),
    .chr_banks     (chr_banks_r),
    .mirror_bit    (mirror_r),
    .prg_bank_mask (prg_mask_r),
    .chr_bank_mask (chr_mask_r),
    .mem_addr      (xl_addr),
    .target        (xl_target)
  );

  assign in_ready  = !skid_valid_r;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign dec_addr  = in_data.address & DECODE_MASK;
  assign tick_cnt  = irq_cnt_r + 8'd1;

  always_comb begin
    prg_banks_nxt = prg_banks_r;
    chr_banks_nxt = chr_banks_r;
    mirror_nxt    = mirror_r;
    irq_cnt_nxt   = irq_cnt_r;
    irq_en_nxt    = irq_en_r;
    irq_lvl_nxt   = irq_lvl_r;
    case (in_data.req_type)
      REQ_WRITE: begin
        if (in_data.address[15]) begin
          case (dec_addr)
            REG_PRG0:   prg_banks_nxt[0] = in_data.write_data;
            REG_MIRROR: mirror_nxt       = in_data.write_data[0];
            REG_PRG1:   prg_banks_nxt[1] = in_data.write_data;
            REG_CHR0:   chr_banks_nxt[0] = in_data.write_data;
            REG_CHR1:   chr_banks_nxt[1] = in_data.write_data;
            REG_CHR2:   chr_banks_nxt[2] = in_data.write_data;
            REG_CHR3:   chr_banks_nxt[3] = in_data.write_data;
            REG_CHR4:   chr_banks_nxt[4] = in_data.write_data;
            REG_CHR5:   chr_banks_nxt[5] = in_data.write_data;
            REG_CHR6:   chr_banks_nxt[6] = in_data.write_data;
            REG_CHR7:   chr_banks_nxt[7] = in_data.write_data;
            REG_IRQ: begin
              irq_en_nxt  = |in_data.write_data;
              irq_cnt_nxt = (in_data.scanline < SCANLINE_VISIBLE_END) ?
                            in_data.write_data - 8'd8 : in_data.write_data + 8'd4;
              irq_lvl_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      REQ_TICK: begin
        if (irq_en_r) begin
          irq_cnt_nxt = tick_cnt;
          if (tick_cnt >= IRQ_THRESHOLD) irq_lvl_nxt = 1'b1;
        end
      end
      default: ;
    endcase
    result.mem_addr = xl_addr;
    result.target   = xl_target;
    result.irq_out  = irq_lvl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_mask_r <= 8'hFF;
      chr_mask_r <= 8'hFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_MASK: prg_mask_r <= cfg_wdata;
        CFG_CHR_MASK: chr_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_banks_r <= '0;
      chr_banks_r <= '0;
      mirror_r    <= 1'b0;
      irq_cnt_r   <= '0;
      irq_en_r    <= 1'b0;
      irq_lvl_r   <= 1'b0;
    end else if (push) begin
      prg_banks_r <= prg_banks_nxt;
      chr_banks_r <= chr_banks_nxt;
      mirror_r    <= mirror_nxt;
      irq_cnt_r   <= irq_cnt_nxt;
      irq_en_r    <= irq_en_nxt;
      irq_lvl_r   <= irq_lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= result;
      end
    end else if (push) begin
      skid_r <= result;
    end
  end

endmodule

FILE: src/cbmsi_xlate.sv
// Address translation for CPU and PPU read requests.
// Depends on cbmsi_pkg; bank registers and masks come from the top level.
module cbmsi_xlate
  import cbmsi_pkg::*;
(
  input  in_item_t        item,
  input  logic [1:0][7:0] prg_banks,
  input  logic [7:0][7:0] chr_banks,
  input  logic            mirror_bit,
  input  logic [7:0]      prg_bank_mask,
  input  logic [7:0]      chr_bank_mask,
  output logic [20:0]     mem_addr,
  output target_t         target
);

  logic [7:0]  prg_bank;
  logic [7:0]  chr_bank;
  logic [13:0] pa;
  logic        page;

  assign pa = item.address[13:0];

  always_comb begin
    case (item.address[14:13])
      2'd0:    prg_bank = prg_banks[0];
      2'd1:    prg_bank = prg_banks[1];
      2'd2:    prg_bank = prg_bank_mask & 8'hFE;
      default: prg_bank = prg_bank_mask;
    endcase
    prg_bank = prg_bank & prg_bank_mask & PRG_FIELD_MASK;
    chr_bank = chr_banks[pa[12:10]] & chr_bank_mask & CHR_FIELD_MASK;
    page     = mirror_bit ? pa[11] : pa[10];

    mem_addr = '0;
    target   = TGT_NONE;
    case (item.req_type)
      REQ_CPU_READ: begin
        if (item.address[15]) begin
          mem_addr = {prg_bank, item.address[12:0]};
          target   = TGT_PRG;
        end
      end
      REQ_PPU_READ: begin
        if (!pa[13]) begin
          mem_addr = {3'd0, chr_bank, pa[9:0]};
          target   = TGT_CHR;
        end else begin
          mem_addr = {10'd0, page, pa[9:0]};
          target   = TGT_CIRAM;
        end
      end
      default: begin
        mem_addr = '0;
        target   = TGT_NONE;
      end
    endcase
  end

endmodule
